[rtl/motor_target_command_parser_macros.svh]
// assertion macros for the motor target command parser
`ifndef MOTOR_TARGET_COMMAND_PARSER_MACROS_SVH
`define MOTOR_TARGET_COMMAND_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define MTCP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MTCP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MTCP_ASSERT(label, clk, rst_n, prop, msg)

`define MTCP_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[rtl/mtcp_pkg.sv]
// types and constants shared by the motor target command parser
`timescale 1ns / 1ps

package mtcp_pkg;

  localparam int VALUE_W    = 32;
  localparam int FRAC_NUM_W = 24;
  localparam int DIGIT_W    = 3;
  localparam int JOB_DEPTH  = 4;
  localparam int JOB_PTR_W  = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;

  localparam logic [FRAC_NUM_W-1:0] POW10 [8] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd10000000
  };

  // bits needed to hold each power of ten minus one
  localparam logic [4:0] POW10_BITS [8] = '{
    5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17, 5'd20, 5'd24
  };

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic               target_valid;
    logic [1:0]         motor_index;
    logic [VALUE_W-1:0] target_value;
    logic               target_saturated;
    logic [3:0]         start_mask;
  } result_t;

  typedef struct packed {
    logic                  target_valid;
    logic [1:0]            motor_index;
    logic [VALUE_W-1:0]    int_part;
    logic                  saturated;
    logic [3:0]            start_mask;
    logic [FRAC_NUM_W-1:0] frac_num;
    logic [DIGIT_W-1:0]    frac_digits;
  } job_t;

endpackage

[rtl/motor_target_command_parser.sv]
// top level of the motor target command parser
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-------------------------------------
//   input     | push / full           | item_i: rx_byte, end_of_buffer
//   result    | empty / pop           | result_o: target_valid, motor_index,
//             |                       |   target_value, target_saturated,
//             |                       |   start_mask
//
// one byte per cycle while full is low; the parser updates its line state and
// writes the job queue in the accepting cycle
// a result passes the job queue and the stage 1, stage 2 and result registers:
//   reciprocal multiply, estimate and back-multiply, correction
// full rises only when the four-entry job queue and the formatter stages are
// all occupied because pop is held low
// reset (rst_ni low, asynchronous) returns the parser to an empty line and
// drops all queued transactions
`timescale 1ns / 1ps

`include "motor_target_command_parser_macros.svh"

module motor_target_command_parser #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  mtcp_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output mtcp_pkg::result_t result_o
);

  logic           accept;
  logic           job_push, job_full, job_pop, job_empty;
  mtcp_pkg::job_t job_in, job_out;

  assign full   = job_full;
  assign accept = push && !job_full;

  mtcp_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  mtcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  mtcp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

  `MTCP_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, job_push && job_full, "job pushed into full queue")

  `MTCP_ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, job_pop && job_empty, "job popped from empty queue")

  `MTCP_ASSERT(a_mask_shape, clk_i, rst_ni, !empty |-> ($onehot0(result_o.start_mask) || ((result_o.start_mask == 4'hF) && !result_o.target_valid)), "bad start mask")

  `MTCP_ASSERT(a_start_all_zero, clk_i, rst_ni, (!empty && !result_o.target_valid) |-> (result_o.target_value == 32'd0), "start-all transaction carries a value")

endmodule

[rtl/mtcp_front.sv]
// byte parser: line tracking, command decoding, number accumulation
`timescale 1ns / 1ps

module mtcp_front #(
  parameter int INT_BITS        = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mtcp_pkg::item_t item_i,
  output logic           job_push_o,
  output mtcp_pkg::job_t job_o
);

  localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DOLLAR = 2'd1;
  localparam logic [1:0] PH_LETTER = 2'd2;
  localparam logic [1:0] PH_NUMBER = 2'd3;

  logic [1:0]                     phase_q, phase_d, phase_a;
  logic                           dollar_q, dollar_d, dollar_a;
  logic [1:0]                     pending_q, pending_a;
  logic [INT_BITS:0]              int_q, int_a;
  logic [FRAC_ACC_W-1:0]          frac_q, frac_a;
  logic [mtcp_pkg::DIGIT_W-1:0]   fd_q, fd_a;
  logic                           point_q, point_a;
  logic [1:0]                     len_q, len_d, len_a;
  logic                           first_q, first_d, first_a;

  logic [7:0]          c;
  logic                is_term, is_letter, is_digit, is_point, end_now;
  logic [1:0]          letter_motor;
  logic [1:0]          fresh_phase;
  logic [3:0]          digit;
  logic [INT_BITS+4:0] int_mul;
  logic [FRAC_ACC_W+3:0] frac_mul;
  logic                emit_num, emit_end, emit_all;

  logic                   sel_dollar;
  logic [1:0]             sel_motor;
  logic [INT_BITS:0]      sel_int;
  logic [FRAC_ACC_W-1:0]  sel_frac;
  logic [mtcp_pkg::DIGIT_W-1:0] sel_fd;
  logic [INT_BITS-1:0]    clamped;

  assign c            = item_i.rx_byte;
  assign is_term      = (c == mtcp_pkg::CH_CR) || (c == mtcp_pkg::CH_LF) ||
                        (c == mtcp_pkg::CH_NUL);
  assign is_letter    = (c >= mtcp_pkg::CH_A) && (c <= mtcp_pkg::CH_D);
  assign is_digit     = (c >= mtcp_pkg::CH_ZERO) && (c <= mtcp_pkg::CH_NINE);
  assign is_point     = (c == mtcp_pkg::CH_POINT);
  assign letter_motor = c[1:0] - 2'd1;
  assign digit        = c[3:0];
  assign fresh_phase  = (c == mtcp_pkg::CH_DOLLAR) ? PH_DOLLAR :
                        is_letter ? PH_LETTER : PH_IDLE;
  assign int_mul      = {4'd0, int_q} * (INT_BITS+5)'(10) + (INT_BITS+5)'(digit);
  assign frac_mul     = {4'd0, frac_q} * (FRAC_ACC_W+4)'(10) + (FRAC_ACC_W+4)'(digit);
  assign end_now      = is_term || item_i.end_of_buffer;

  // state after the byte itself, before any line end
  always_comb begin
    phase_a   = phase_q;
    dollar_a  = dollar_q;
    pending_a = pending_q;
    int_a     = int_q;
    frac_a    = frac_q;
    fd_a      = fd_q;
    point_a   = point_q;
    len_a     = len_q;
    first_a   = first_q;
    emit_num  = 1'b0;
    if (!is_term) begin
      if (len_q == 2'd0) begin
        first_a = (c == mtcp_pkg::CH_DOLLAR);
      end
      if (len_q < 2'd2) begin
        len_a = len_q + 2'd1;
      end
      case (phase_q)
        PH_IDLE: begin
          phase_a  = fresh_phase;
          dollar_a = (c == mtcp_pkg::CH_DOLLAR);
          if (is_letter) begin
            pending_a = letter_motor;
          end
        end
        PH_DOLLAR: begin
          if (is_letter) begin
            pending_a = letter_motor;
            phase_a   = PH_LETTER;
          end else begin
            phase_a  = PH_IDLE;
            dollar_a = 1'b0;
          end
        end
        PH_LETTER: begin
          if (c == mtcp_pkg::CH_COLON) begin
            phase_a = PH_NUMBER;
            int_a   = '0;
            frac_a  = '0;
            fd_a    = '0;
            point_a = 1'b0;
          end else begin
            phase_a  = fresh_phase;
            dollar_a = (c == mtcp_pkg::CH_DOLLAR);
            if (is_letter) begin
              pending_a = letter_motor;
            end
          end
        end
        default: begin
          if (is_point) begin
            point_a = 1'b1;
          end else if (is_digit) begin
            if (!point_q) begin
              if (int_mul > (INT_BITS+5)'(1) << INT_BITS) begin
                int_a = (INT_BITS+1)'(1) << INT_BITS;
              end else begin
                int_a = int_mul[INT_BITS:0];
              end
            end else if (fd_q < mtcp_pkg::DIGIT_W'(MAX_FRAC_DIGITS)) begin
              frac_a = frac_mul[FRAC_ACC_W-1:0];
              fd_a   = fd_q + 1'b1;
            end
          end else begin
            emit_num = 1'b1;
            phase_a  = fresh_phase;
            dollar_a = (c == mtcp_pkg::CH_DOLLAR);
            if (is_letter) begin
              pending_a = letter_motor;
            end
          end
        end
      endcase
    end
  end

  // line end
  always_comb begin
    emit_end = 1'b0;
    emit_all = 1'b0;
    phase_d  = phase_a;
    dollar_d = dollar_a;
    len_d    = len_a;
    first_d  = first_a;
    if (end_now) begin
      if (!emit_num && (phase_a == PH_NUMBER)) begin
        emit_end = 1'b1;
      end else if (!emit_num && (len_a == 2'd1) && first_a) begin
        emit_all = 1'b1;
      end
      phase_d  = PH_IDLE;
      dollar_d = 1'b0;
      len_d    = 2'd0;
      first_d  = 1'b0;
    end
  end

  // a target is built from the state before the byte when the byte closes the number
  always_comb begin
    sel_dollar = emit_num ? dollar_q  : dollar_a;
    sel_motor  = emit_num ? pending_q : pending_a;
    sel_int    = emit_num ? int_q     : int_a;
    sel_frac   = emit_num ? frac_q    : frac_a;
    sel_fd     = emit_num ? fd_q      : fd_a;
    clamped    = sel_int[INT_BITS] ? '1 : sel_int[INT_BITS-1:0];

    job_o.target_valid = !emit_all;
    job_o.motor_index  = emit_all ? 2'd0 : sel_motor;
    job_o.int_part     = emit_all ? '0 : mtcp_pkg::VALUE_W'(clamped);
    job_o.saturated    = !emit_all && sel_int[INT_BITS];
    job_o.start_mask   = emit_all ? 4'hF :
                         sel_dollar ? (4'd1 << sel_motor) : 4'd0;
    job_o.frac_num     = emit_all ? '0 : mtcp_pkg::FRAC_NUM_W'(sel_frac);
    job_o.frac_digits  = emit_all ? '0 : sel_fd;
  end

  assign job_push_o = accept_i && (emit_num || emit_end || emit_all);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      dollar_q  <= 1'b0;
      pending_q <= '0;
      int_q     <= '0;
      frac_q    <= '0;
      fd_q      <= '0;
      point_q   <= 1'b0;
      len_q     <= '0;
      first_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      dollar_q  <= dollar_d;
      pending_q <= pending_a;
      int_q     <= int_a;
      frac_q    <= frac_a;
      fd_q      <= fd_a;
      point_q   <= point_a;
      len_q     <= len_d;
      first_q   <= first_d;
    end
  end

endmodule

[rtl/mtcp_queue.sv]
// short job queue between parser and value formatter
`timescale 1ns / 1ps

module mtcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtcp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mtcp_pkg::job_t data_o
);

  mtcp_pkg::job_t                 entry_q [mtcp_pkg::JOB_DEPTH];
  logic [mtcp_pkg::JOB_PTR_W:0]   wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[mtcp_pkg::JOB_PTR_W] != rd_q[mtcp_pkg::JOB_PTR_W]) &&
                   (wr_q[mtcp_pkg::JOB_PTR_W-1:0] == rd_q[mtcp_pkg::JOB_PTR_W-1:0]);
  assign data_o  = entry_q[rd_q[mtcp_pkg::JOB_PTR_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entry_q[wr_q[mtcp_pkg::JOB_PTR_W-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

[rtl/mtcp_back.sv]
// fraction scaling pipeline and result register
`timescale 1ns / 1ps

module mtcp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  mtcp_pkg::job_t    job_i,
  output logic              job_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mtcp_pkg::result_t result_o
);

  localparam int RW  = FRAC_BITS + 2;
  localparam int XW  = mtcp_pkg::FRAC_NUM_W;
  localparam int P1W = XW + RW;
  localparam int P2W = XW + FRAC_BITS;

  // floor(2^(FRAC_BITS + bits + 1) / 10^n)
  localparam logic [63:0] RECIP [8] = '{
    (64'd1 << (FRAC_BITS + 1))  / 64'd1,
    (64'd1 << (FRAC_BITS + 5))  / 64'd10,
    (64'd1 << (FRAC_BITS + 8))  / 64'd100,
    (64'd1 << (FRAC_BITS + 11)) / 64'd1000,
    (64'd1 << (FRAC_BITS + 15)) / 64'd10000,
    (64'd1 << (FRAC_BITS + 18)) / 64'd100000,
    (64'd1 << (FRAC_BITS + 21)) / 64'd1000000,
    (64'd1 << (FRAC_BITS + 25)) / 64'd10000000
  };

  mtcp_pkg::job_t    s1_job_q, s2_job_q;
  logic              s1_v_q, s2_v_q, out_v_q;
  logic [P1W-1:0]    s1_prod_q;
  logic [FRAC_BITS-1:0] s2_q0_q;
  logic [P2W-1:0]    s2_prod_q;
  mtcp_pkg::result_t out_q, out_d;

  logic              out_rdy, s2_rdy, s1_rdy;
  logic [RW-1:0]     recip;
  logic [P1W-1:0]    prod1_d;
  logic [5:0]        shamt;
  logic [P1W-1:0]    shifted;
  logic [FRAC_BITS-1:0] q0_d;
  logic [P2W-1:0]    prod2_d;
  logic [P2W-1:0]    diff;
  logic [XW+1:0]     rem;
  logic [FRAC_BITS-1:0] q;
  logic [mtcp_pkg::VALUE_W+FRAC_BITS-1:0] full_value;

  assign out_rdy   = !out_v_q || pop_i;
  assign s2_rdy    = !s2_v_q || out_rdy;
  assign s1_rdy    = !s1_v_q || s2_rdy;
  assign job_pop_o = !job_empty_i && s1_rdy;

  // stage 1: numerator times scaled reciprocal
  assign recip   = RECIP[job_i.frac_digits][RW-1:0];
  assign prod1_d = P1W'(job_i.frac_num) * P1W'(recip);

  // stage 2: estimate, then back-multiply by the divisor
  assign shamt   = 6'(mtcp_pkg::POW10_BITS[s1_job_q.frac_digits]) + 6'd1;
  assign shifted = s1_prod_q >> shamt;
  assign q0_d    = shifted[FRAC_BITS-1:0];
  assign prod2_d = P2W'(q0_d) * P2W'(mtcp_pkg::POW10[s1_job_q.frac_digits]);

  // stage 3: the estimate is at most one short
  assign diff = {s2_job_q.frac_num, {FRAC_BITS{1'b0}}} - s2_prod_q;
  assign rem  = diff[XW+1:0];
  assign q    = s2_q0_q + FRAC_BITS'(rem >= {2'b00, mtcp_pkg::POW10[s2_job_q.frac_digits]});
  assign full_value = {s2_job_q.int_part, {FRAC_BITS{1'b0}}} |
                      (mtcp_pkg::VALUE_W+FRAC_BITS)'(q);

  always_comb begin
    out_d.target_valid     = s2_job_q.target_valid;
    out_d.motor_index      = s2_job_q.motor_index;
    out_d.target_value     = full_value[mtcp_pkg::VALUE_W-1:0];
    out_d.target_saturated = s2_job_q.saturated;
    out_d.start_mask       = s2_job_q.start_mask;
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_job_q  <= job_i;
      s1_prod_q <= prod1_d;
    end
    if (s2_rdy) begin
      s2_job_q  <= s1_job_q;
      s2_q0_q   <= q0_d;
      s2_prod_q <= prod2_d;
    end
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= !job_empty_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign empty_o  = !out_v_q;
  assign result_o = out_q;

endmodule
